/* rtl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// shared types and constants for the sliding window maximum block
// ----------------------------------------------------------------------------
package swm_pkg;

    // width of the window length register
    localparam int LEN_W = 11;

    // control from the top level to the deque engine
    typedef struct packed {
        logic start;     // input transfer this cycle
        logic out_free;  // output register can take a result this cycle
    } swm_ctrl_t;

    // status from the deque engine to the top level
    typedef struct packed {
        logic idle;      // engine can take a new item
        logic done;      // result fields valid, loaded into the output register
    } swm_stat_t;

endpackage

/* rtl/swm_engine.sv */
// ----------------------------------------------------------------------------
// swm_engine
// monotonic deque in a candidate memory with one read and one write port,
// walked by a small sequencer
// ----------------------------------------------------------------------------
module swm_engine #(
    parameter int WINDOW_MAX = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  swm_pkg::swm_ctrl_t         ctrl,
    input  logic [VALUE_BITS-1:0]      sample_value,
    input  logic [swm_pkg::LEN_W-1:0]  window_length,
    output swm_pkg::swm_stat_t         stat,
    output logic [VALUE_BITS-1:0]      res_echo,
    output logic [VALUE_BITS-1:0]      res_max
);
    import swm_pkg::*;

    localparam int IDX_W   = $clog2(WINDOW_MAX);
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int POS_MOD = 2 * WINDOW_MAX;
    localparam int POS_W   = $clog2(POS_MOD);
    localparam int CMP_W   = (LEN_W > CNT_W) ? LEN_W : CNT_W;
    localparam int MW      = POS_W + VALUE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_TAIL_RD,
        S_TAIL_CHK,
        S_WRITE
    } state_t;

    state_t                state_reg;
    logic [IDX_W-1:0]      head_reg;
    logic [IDX_W-1:0]      tail_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] head_val_reg;
    logic [CNT_W-1:0]      len_reg;

    logic [MW-1:0]         mem [WINDOW_MAX];
    logic [MW-1:0]         rd_data_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;

    logic [IDX_W-1:0]      head_succ;
    logic [IDX_W-1:0]      tail_succ;
    logic [IDX_W-1:0]      tail_pred;
    logic [POS_W-1:0]      pos_next;
    logic [CMP_W-1:0]      len_ext;
    logic [CNT_W-1:0]      len_eff;
    logic [POS_W-1:0]      rd_pos;
    logic [VALUE_BITS-1:0] rd_val;
    logic [POS_W:0]        age_diff;
    logic [POS_W-1:0]      age;
    logic                  expired;
    logic                  out_go;

    // ring arithmetic, also valid for depths that are not a power of two
    assign head_succ = (head_reg == IDX_W'(WINDOW_MAX - 1)) ? '0 : head_reg + IDX_W'(1);
    assign tail_succ = (tail_reg == IDX_W'(WINDOW_MAX - 1)) ? '0 : tail_reg + IDX_W'(1);
    assign tail_pred = (tail_reg == '0) ? IDX_W'(WINDOW_MAX - 1) : tail_reg - IDX_W'(1);
    assign pos_next  = (pos_reg == POS_W'(POS_MOD - 1)) ? '0 : pos_reg + POS_W'(1);

    // zero acts as one, oversized lengths clamp to the deque depth
    assign len_ext = CMP_W'(window_length);
    always_comb
    begin
        if (len_ext == '0)
            len_eff = CNT_W'(1);
        else if (len_ext > CMP_W'(WINDOW_MAX))
            len_eff = CNT_W'(WINDOW_MAX);
        else
            len_eff = len_ext[CNT_W-1:0];
    end

    assign rd_pos = rd_data_reg[MW-1:VALUE_BITS];
    assign rd_val = rd_data_reg[VALUE_BITS-1:0];

    // age modulo twice the depth
    assign age_diff = {1'b0, pos_reg} - {1'b0, rd_pos};
    assign age      = age_diff[POS_W] ? POS_W'(age_diff + (POS_W + 1)'(POS_MOD))
                                      : age_diff[POS_W-1:0];
    assign expired  = (age >= POS_W'(len_reg));

    assign rd_addr = (state_reg == S_TAIL_RD) ? tail_pred : head_reg;
    assign out_go  = (state_reg == S_WRITE) && ctrl.out_free;
    assign mem_we  = out_go && (count_reg != CNT_W'(WINDOW_MAX));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[tail_reg] <= {pos_reg, val_reg};
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            pos_reg      <= '0;
            val_reg      <= '0;
            head_val_reg <= '0;
            len_reg      <= CNT_W'(1);
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        val_reg   <= sample_value;
                        len_reg   <= len_eff;
                        state_reg <= (count_reg == '0) ? S_WRITE : S_HEAD_RD;
                    end
                end
                S_HEAD_RD:
                begin
                    state_reg <= S_HEAD_CHK;
                end
                S_HEAD_CHK:
                begin
                    if (expired)
                    begin
                        head_reg  <= head_succ;
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= (count_reg == CNT_W'(1)) ? S_WRITE : S_HEAD_RD;
                    end
                    else
                    begin
                        head_val_reg <= rd_val;
                        state_reg    <= S_TAIL_RD;
                    end
                end
                S_TAIL_RD:
                begin
                    state_reg <= S_TAIL_CHK;
                end
                S_TAIL_CHK:
                begin
                    if (rd_val > val_reg)
                        state_reg <= S_WRITE;
                    else
                    begin
                        tail_reg  <= tail_pred;
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= (count_reg == CNT_W'(1)) ? S_WRITE : S_TAIL_RD;
                    end
                end
                S_WRITE:
                begin
                    if (ctrl.out_free)
                    begin
                        if (count_reg != CNT_W'(WINDOW_MAX))
                        begin
                            tail_reg  <= tail_succ;
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        pos_reg   <= pos_next;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = out_go;
    assign res_echo  = val_reg;
    // an empty deque here means every candidate expired or lost to the new value
    assign res_max   = (count_reg == '0) ? val_reg : head_val_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_MAX))
        else $error("deque count above depth");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> stat.idle)
        else $error("item started while engine busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> stat.idle)
        else $error("engine not idle after result");

    a_done_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.done && $past(stat.idle) && (count_reg == '0)) |=> (count_reg == CNT_W'(1)))
        else $error("empty deque not refilled with the new value");
`endif

endmodule

/* rtl/sliding_window_maximum.sv */
// ----------------------------------------------------------------------------
// sliding_window_maximum
// echoes each sample and returns the maximum over the last window_length samples
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | in_valid, in_ready, sample_value     | in
//  output   | out_valid, out_ready, echo_value,    | out
//           | window_max                           |
//  config   | cfg_valid, cfg_ready, window_length  | in
//
// an item is a series of deque reads: expired heads, the head that survives and the
// tail compares; each read state is followed by its compare state, then S_WRITE
// a deque that is empty at the start or emptied by expiry skips the tail walk
// reset empties the deque and sets the window length to 1; no clearing pass
// a result waits in the output register; the engine stalls only when it holds
// a second result and that register is still full
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
    parameter int WINDOW_MAX = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [VALUE_BITS-1:0]      sample_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [VALUE_BITS-1:0]      echo_value,
    output logic [VALUE_BITS-1:0]      window_max,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [swm_pkg::LEN_W-1:0]  window_length
);
    import swm_pkg::*;

    logic [LEN_W-1:0]      window_length_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] echo_value_reg;
    logic [VALUE_BITS-1:0] window_max_reg;

    swm_ctrl_t             ctrl;
    swm_stat_t             stat;
    logic [VALUE_BITS-1:0] res_echo;
    logic [VALUE_BITS-1:0] res_max;

    assign cfg_ready     = 1'b1;
    assign in_ready      = stat.idle;
    assign ctrl.start    = in_valid && stat.idle;
    assign ctrl.out_free = !out_valid_reg || out_ready;

    swm_engine #(
        .WINDOW_MAX (WINDOW_MAX),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .sample_value  (sample_value),
        .window_length (window_length_reg),
        .stat          (stat),
        .res_echo      (res_echo),
        .res_max       (res_max)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_length_reg <= LEN_W'(1);
        else if (cfg_valid)
            window_length_reg <= window_length;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stat.done)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            echo_value_reg <= res_echo;
            window_max_reg <= res_max;
        end
    end

    assign out_valid  = out_valid_reg;
    assign echo_value = echo_value_reg;
    assign window_max = window_max_reg;

endmodule
